// File: hdl/isa_pkg.sv
// Shared constants, codes and control types for the indexed stack array.
package isa_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = 6;
  localparam int CNT_W  = 7;
  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int TDATA_IN_W  = 48;
  localparam int TDATA_OUT_W = 48;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_SET    = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADIDX = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the accepted item
    logic rd_issue;    // read the word for pop, peek or get
    logic shift_init;  // set the shift pointer just above the removed slot
    logic shift_rd;    // read the word at the shift pointer
    logic shift_wr;    // write it one slot down and advance
    logic commit;      // apply the operation and load the result register
  } isa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_read;   // operation succeeds and returns a stored word
    logic need_shift;  // successful remove with words above the index
    logic shift_last;  // the current shift moves the top word
    logic out_free;    // result register can take a new result
  } isa_stat_t;

endpackage

// File: hdl/isa_ctrl.sv
// Controller state machine that sequences one operation at a time.
module isa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  isa_pkg::isa_stat_t stat,
  output isa_pkg::isa_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_SHIFT_RD = 3'd2;
  localparam logic [2:0] S_SHIFT_WR = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Decode state into datapath commands and pick the next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.need_read) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_DONE;
        end else if (stat.need_shift) begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = stat.shift_last ? S_DONE : S_SHIFT_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/isa_datapath.sv
// Datapath: slot memory, fill count, capacity register and result register.
module isa_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  isa_pkg::isa_cmd_t                cmd,
  output isa_pkg::isa_stat_t               stat,
  input  logic [isa_pkg::OP_W-1:0]         in_opcode,
  input  logic [isa_pkg::ADDR_W-1:0]       in_index,
  input  logic [isa_pkg::WORD_W-1:0]       in_value,
  input  logic                             cfg_we,
  input  logic [isa_pkg::CNT_W-1:0]        cfg_capacity,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [isa_pkg::ST_W-1:0]         out_status,
  output logic [isa_pkg::WORD_W-1:0]       out_data,
  output logic [isa_pkg::CNT_W-1:0]        out_count
);

  localparam logic [isa_pkg::CNT_W-1:0] DEPTH_CNT = isa_pkg::CNT_W'(isa_pkg::DEPTH);
  localparam logic [isa_pkg::CNT_W-1:0] ONE_CNT   = isa_pkg::CNT_W'(1);

  logic [isa_pkg::WORD_W-1:0] mem [isa_pkg::DEPTH];

  logic [isa_pkg::OP_W-1:0]   op_q;
  logic [isa_pkg::ADDR_W-1:0] idx_q;
  logic [isa_pkg::WORD_W-1:0] val_q;
  logic [isa_pkg::CNT_W-1:0]  count;
  logic [isa_pkg::CNT_W-1:0]  count_next;
  logic [isa_pkg::CNT_W-1:0]  capacity;
  logic [isa_pkg::ADDR_W-1:0] ptr;
  logic [isa_pkg::WORD_W-1:0] rdata;

  logic [isa_pkg::CNT_W-1:0]  cap_eff;
  logic [isa_pkg::CNT_W-1:0]  idx_ext;
  logic [isa_pkg::CNT_W-1:0]  count_m1;
  logic                       is_push, is_pop, is_peek, is_get, is_set, is_remove;
  logic                       err_full, err_empty, err_idx, op_ok;
  logic [isa_pkg::ST_W-1:0]   status_code;
  logic                       rd_en;
  logic [isa_pkg::ADDR_W-1:0] rd_addr;
  logic                       we;
  logic [isa_pkg::ADDR_W-1:0] wr_addr;
  logic [isa_pkg::WORD_W-1:0] wr_data;

  // Decode the captured operation and check it against the count
  always_comb begin
    is_push   = (op_q == isa_pkg::OP_PUSH);
    is_pop    = (op_q == isa_pkg::OP_POP);
    is_peek   = (op_q == isa_pkg::OP_PEEK);
    is_get    = (op_q == isa_pkg::OP_GET);
    is_set    = (op_q == isa_pkg::OP_SET);
    is_remove = (op_q == isa_pkg::OP_REMOVE);
    cap_eff   = (capacity > DEPTH_CNT) ? DEPTH_CNT : capacity;
    idx_ext   = {1'b0, idx_q};
    count_m1  = count - ONE_CNT;
    err_full  = is_push && (count >= cap_eff);
    err_empty = (is_pop || is_peek) && (count == '0);
    err_idx   = (is_get || is_set || is_remove) && (idx_ext >= count);
    op_ok     = !(err_full || err_empty || err_idx);
    if (err_full) begin
      status_code = isa_pkg::ST_FULL;
    end else if (err_empty) begin
      status_code = isa_pkg::ST_EMPTY;
    end else if (err_idx) begin
      status_code = isa_pkg::ST_BADIDX;
    end else begin
      status_code = isa_pkg::ST_OK;
    end
  end

  // Report status to the controller
  always_comb begin
    stat.need_read  = op_ok && (is_pop || is_peek || is_get);
    stat.need_shift = op_ok && is_remove && ((idx_ext + ONE_CNT) < count);
    stat.shift_last = (({1'b0, ptr} + ONE_CNT) == count);
    stat.out_free   = !out_valid || out_ready;
  end

  // Select memory read and write ports
  always_comb begin
    rd_en   = cmd.rd_issue || cmd.shift_rd;
    if (cmd.shift_rd) begin
      rd_addr = ptr;
    end else if (is_get) begin
      rd_addr = idx_q;
    end else begin
      rd_addr = count_m1[isa_pkg::ADDR_W-1:0];
    end
    we      = cmd.shift_wr || (cmd.commit && op_ok && (is_push || is_set));
    if (cmd.shift_wr) begin
      wr_addr = ptr - isa_pkg::ADDR_W'(1);
      wr_data = rdata;
    end else if (is_push) begin
      wr_addr = count[isa_pkg::ADDR_W-1:0];
      wr_data = val_q;
    end else begin
      wr_addr = idx_q;
      wr_data = val_q;
    end
  end

  // Slot memory with registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Work out the count after the operation
  always_comb begin
    count_next = count;
    if (op_ok && is_push) begin
      count_next = count + ONE_CNT;
    end else if (op_ok && (is_pop || is_remove)) begin
      count_next = count_m1;
    end
  end

  // Capture the item and step the shift pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_opcode;
      idx_q <= in_index;
      val_q <= in_value;
    end
    if (cmd.shift_init) begin
      ptr <= idx_q + isa_pkg::ADDR_W'(1);
    end else if (cmd.shift_wr) begin
      ptr <= ptr + isa_pkg::ADDR_W'(1);
    end
  end

  // Hold the fill count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= DEPTH_CNT;
    end else begin
      if (cmd.commit) begin
        count <= count_next;
      end
      if (cfg_we) begin
        capacity <= cfg_capacity;
      end
    end
  end

  // Result register: load on commit, drop when the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= status_code;
      out_data   <= stat.need_read ? rdata : '0;
      out_count  <= count_next;
    end
  end

endmodule

// File: hdl/indexed_stack_array_core.sv
// Bounded stack of 64 words of 32 bits with indexed get, set and remove.
// One item is in work at a time. Push, pop, peek, get, set, errors and
// unknown opcodes each pass from one transfer in to the next transfer in through
// capture, execute with the slot memory read, and commit to the result register.
// A successful remove with words above its index adds a shift pass before
// commit: the single-port-write slot memory moves each such word down one
// place, with a read state and then a write state for each word. The
// result register lets the next item be taken while the previous result still
// waits downstream; the block only stalls at commit when that register is still
// full. The capacity register (reset 64, values above 64 act as 64) is written
// through the cfg channel, which is always ready. There is no clearing pass after reset.
module indexed_stack_array_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // opcode[2:0], index[8:3], value[40:9], zero[47:41]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // status[1:0], data[33:2], count[40:34], zero[47:41]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data        // capacity
);

  isa_pkg::isa_cmd_t  cmd;
  isa_pkg::isa_stat_t stat;

  logic [isa_pkg::ST_W-1:0]   out_status;
  logic [isa_pkg::WORD_W-1:0] out_data;
  logic [isa_pkg::CNT_W-1:0]  out_count;

  assign cfg_ready = 1'b1;

  isa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  isa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_opcode    (s_axis_tdata[2:0]),
    .in_index     (s_axis_tdata[8:3]),
    .in_value     (s_axis_tdata[40:9]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (cfg_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_count    (out_count)
  );

  // Pack the result
  assign m_axis_tdata = {7'd0, out_count, out_data, out_status};

`ifndef SYNTHESIS
  // One item in work: input closes right after a transfer in
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // Commit only when the result register can take the result
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit while result register is occupied");

  // A commit presents a result on the next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_axis_tvalid)
    else $error("committed result not presented");

  // Fill count never exceeds the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_count <= isa_pkg::CNT_W'(isa_pkg::DEPTH)))
    else $error("result count beyond depth");
`endif

endmodule

// File: tb/indexed_stack_array_core_tb.sv
// Self-checking testbench for the indexed stack array core: directed and random operations.
`timescale 1ns / 100ps

module indexed_stack_array_core_tb;

  localparam logic [isa_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [isa_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [isa_pkg::ST_W-1:0]   status;
    logic [isa_pkg::WORD_W-1:0] data;
    logic [isa_pkg::CNT_W-1:0]  count;
  } stack_result_t;

  // Track the stack contents and hold the results it must produce, in order
  class stack_scoreboard;
    logic [isa_pkg::WORD_W-1:0] slot_mem [isa_pkg::DEPTH];
    int                         fill;
    logic [isa_pkg::CNT_W-1:0]  capacity;
    stack_result_t              expected_results [$];
    int                         mismatches;
    int                         items_seen;
    int                         results_seen;
    int                         capacity_writes;
    int                         status_hits [4];

    function new();
      foreach (slot_mem[i]) slot_mem[i] = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
      fill            = 0;
      capacity        = isa_pkg::CNT_W'(isa_pkg::DEPTH);
      mismatches      = 0;
      items_seen      = 0;
      results_seen    = 0;
      capacity_writes = 0;
    endfunction

    function int fill_level();
      return fill;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_capacity(logic [isa_pkg::CNT_W-1:0] value);
      capacity = value;
      capacity_writes++;
    endfunction

    // Apply one accepted operation and queue the result it yields
    function void note_item(logic [isa_pkg::TDATA_IN_W-1:0] tdata);
      logic [isa_pkg::OP_W-1:0]   op;
      logic [isa_pkg::ADDR_W-1:0] idx;
      logic [isa_pkg::WORD_W-1:0] word;
      stack_result_t              res;
      int                         usable;
      int                         i;
      op     = tdata[2:0];
      idx    = tdata[8:3];
      word   = tdata[40:9];
      res    = '0;
      usable = (capacity > isa_pkg::DEPTH) ? isa_pkg::DEPTH : int'(capacity);
      case (op)
        isa_pkg::OP_PUSH: begin
          if (fill >= usable) begin
            res.status = isa_pkg::ST_FULL;
          end else begin
            slot_mem[fill] = word;
            fill++;
          end
        end
        isa_pkg::OP_POP, isa_pkg::OP_PEEK: begin
          if (fill == 0) begin
            res.status = isa_pkg::ST_EMPTY;
          end else begin
            res.data = slot_mem[fill-1];
            if (op == isa_pkg::OP_POP) fill--;
          end
        end
        isa_pkg::OP_GET, isa_pkg::OP_SET, isa_pkg::OP_REMOVE: begin
          if (int'(idx) >= fill) begin
            res.status = isa_pkg::ST_BADIDX;
          end else if (op == isa_pkg::OP_GET) begin
            res.data = slot_mem[idx];
          end else if (op == isa_pkg::OP_SET) begin
            slot_mem[idx] = word;
          end else begin
            // Close the gap and clear the vacated top slot
            for (i = idx; i + 1 < fill; i++) slot_mem[i] = slot_mem[i+1];
            slot_mem[fill-1] = '0;
            fill--;
          end
        end
        default: ;
      endcase
      res.count = isa_pkg::CNT_W'(fill);
      status_hits[res.status]++;
      items_seen++;
      expected_results.push_back(res);
    endfunction

    function void flag(string field, logic [isa_pkg::WORD_W-1:0] want,
                       logic [isa_pkg::WORD_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("MISMATCH at result %0d, %s: expected %0h, actual %0h",
                 results_seen, field, want, got);
    endfunction

    // Compare one output transfer with the oldest queued result
    function void check_result(logic [isa_pkg::TDATA_OUT_W-1:0] tdata);
      stack_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        flag("result with nothing queued", '0, tdata[33:2]);
        return;
      end
      want = expected_results.pop_front();
      if (tdata[1:0] != want.status)
        flag("status", isa_pkg::WORD_W'(want.status), isa_pkg::WORD_W'(tdata[1:0]));
      if (tdata[33:2] != want.data)
        flag("data", want.data, tdata[33:2]);
      if (tdata[40:34] != want.count)
        flag("count", isa_pkg::WORD_W'(want.count), isa_pkg::WORD_W'(tdata[40:34]));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [isa_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [isa_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [isa_pkg::CNT_W-1:0]       cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  stack_scoreboard sb = new();

  indexed_stack_array_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Randomly hold off the result stream
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Observe transfers and stop on a stalled run
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (cfg_valid && cfg_ready) sb.write_capacity(cfg_data);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one operation, with a random gap first, and hold it until transfer
  task send_item(input logic [isa_pkg::OP_W-1:0] op, input logic [isa_pkg::ADDR_W-1:0] idx,
                 input logic [isa_pkg::WORD_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, value, idx, op};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued result has come out
  task wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_capacity(input logic [isa_pkg::CNT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly legal operations on live slots, with some noise mixed in
  task run_segment(input int push_pct, input int n_items);
    logic [isa_pkg::OP_W-1:0]   op;
    logic [isa_pkg::ADDR_W-1:0] idx;
    logic [isa_pkg::WORD_W-1:0] value;
    int                         fill;
    int                         pick;
    repeat (n_items) begin
      fill = sb.fill_level();
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < push_pct) op = isa_pkg::OP_PUSH;
      else if (pick < 15) op = isa_pkg::OP_POP;
      else if (pick < 25) op = isa_pkg::OP_PEEK;
      else if (pick < 45) op = isa_pkg::OP_GET;
      else if (pick < 65) op = isa_pkg::OP_SET;
      else if (pick < 85) op = isa_pkg::OP_REMOVE;
      else if (pick < 90) op = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
      else op = isa_pkg::OP_W'($urandom_range(0, 7));
      if (fill > 0 && $urandom_range(0, 9) < 8)
        idx = isa_pkg::ADDR_W'($urandom_range(0, fill - 1));
      else
        idx = isa_pkg::ADDR_W'($urandom_range(0, isa_pkg::DEPTH - 1));
      pick = $urandom_range(0, 19);
      if (pick == 0) value = '0;
      else if (pick == 1) value = '1;
      else value = $urandom;
      send_item(op, idx, value);
    end
  endtask

  initial begin
    int phase;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: errors on an empty stack, then each operation on a few words
    send_item(isa_pkg::OP_POP,    '0, '0);
    send_item(isa_pkg::OP_PEEK,   '0, '1);
    send_item(isa_pkg::OP_GET,    '0, '0);
    send_item(isa_pkg::OP_SET,    '1, '1);
    send_item(isa_pkg::OP_REMOVE, '0, '0);
    send_item(isa_pkg::OP_PUSH,   '0, '0);
    send_item(isa_pkg::OP_PUSH,   '1, '1);
    send_item(isa_pkg::OP_PUSH,   6'h15, 32'hA5A5_A5A5);
    send_item(isa_pkg::OP_PEEK,   '0, '0);
    send_item(isa_pkg::OP_GET,    6'd0, '0);
    send_item(isa_pkg::OP_GET,    6'd1, '0);
    send_item(isa_pkg::OP_GET,    6'd2, '0);
    send_item(isa_pkg::OP_GET,    6'd3, '0);
    send_item(isa_pkg::OP_SET,    6'd1, 32'h5A5A_5A5A);
    send_item(isa_pkg::OP_GET,    6'd1, '0);
    send_item(isa_pkg::OP_REMOVE, 6'd0, '1);
    send_item(isa_pkg::OP_GET,    6'd0, '0);
    send_item(isa_pkg::OP_REMOVE, 6'd2, '0);
    send_item(OP_SPARE_LO, '1, '1);
    send_item(OP_SPARE_HI, 6'h2A, 32'h1234_5678);
    send_item(isa_pkg::OP_POP,    '0, '0);
    send_item(isa_pkg::OP_POP,    '0, '0);
    send_item(isa_pkg::OP_POP,    '0, '0);
    send_item(isa_pkg::OP_GET,    '1, '0);

    // Random: three pacing phases, each over several capacity settings
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 0) begin
        send_idle_pct = 21;
        recv_idle_pct = 86;
      end else if (phase == 1) begin
        send_idle_pct = 86;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Fill to the top, with capacity at the depth or, in phases 0 and 2, saturating above it
      write_capacity((phase == 1) ? isa_pkg::CNT_W'(isa_pkg::DEPTH) : '1);
      run_segment(70, 200);
      // Drop capacity below the count and drain
      write_capacity((phase == 1) ? isa_pkg::CNT_W'(1) : isa_pkg::CNT_W'(5));
      run_segment(25, 100);
      // Every push reports full
      write_capacity('0);
      run_segment(30, 60);
      write_capacity(isa_pkg::CNT_W'($urandom_range(0, 127)));
      run_segment(40, 120);
    end

    wait_idle();
    $display("Covered %0d operations and %0d results over %0d capacity writes",
             sb.items_seen, sb.results_seen, sb.capacity_writes);
    $display("Status mix: ok %0d, full %0d, empty %0d, bad index %0d",
             sb.status_hits[isa_pkg::ST_OK], sb.status_hits[isa_pkg::ST_FULL],
             sb.status_hits[isa_pkg::ST_EMPTY], sb.status_hits[isa_pkg::ST_BADIDX]);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching fields", sb.mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/isa_pkg.sv
hdl/isa_ctrl.sv
hdl/isa_datapath.sv
hdl/indexed_stack_array_core.sv
tb/indexed_stack_array_core_tb.sv
